// ----- src/sipq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted queue package
// Shared constants and request codes for the sorted insert / pop-min queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sipq_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int VALUE_W          = 32;
  localparam int OCC_W            = 5;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

endpackage

`default_nettype wire

// ----- src/sipq_req_if.sv -----
// ----------------------------------------------------------------------------
// Sorted queue request channel
// Valid/ready channel carrying one insert or remove request per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface sipq_req_if;
  import sipq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

`default_nettype wire

// ----- src/sipq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Sorted queue response channel
// Valid/ready channel carrying one result per request transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface sipq_rsp_if;
  import sipq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] removed_value;
  logic                      removed_valid;
  logic                      overflow;
  logic [OCC_W-1:0]          occupancy;

  modport source (output valid, output removed_value, output removed_valid,
                  output overflow, output occupancy, input ready);
  modport sink   (input valid, input removed_value, input removed_valid,
                  input overflow, input occupancy, output ready);
endinterface

`default_nettype wire

// ----- src/sipq_ram.sv -----
// ----------------------------------------------------------------------------
// Sorted queue entry store
// Single write port, single read port memory with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sipq_ram
  import sipq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY,
  localparam int PTR_W   = $clog2(CAPACITY)
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [PTR_W-1:0]          waddr,
  input  wire logic signed [VALUE_W-1:0] wdata,
  input  wire logic [PTR_W-1:0]          raddr,
  output logic signed [VALUE_W-1:0]      rdata
);

  logic signed [VALUE_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/sipq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sorted queue sequencer
// Keeps the entries as a ring in the store, ordered from the head, and runs
// insertion steps from the tail, one read and compare per step.
// ----------------------------------------------------------------------------
`default_nettype none

module sipq_ctrl
  import sipq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY,
  localparam int PTR_W   = $clog2(CAPACITY),
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  sipq_req_if.sink                       req,
  sipq_rsp_if.source                     rsp,
  output logic                           mem_we,
  output logic [PTR_W-1:0]               mem_waddr,
  output logic signed [VALUE_W-1:0]      mem_wdata,
  output logic [PTR_W-1:0]               mem_raddr,
  input  wire logic signed [VALUE_W-1:0] mem_rdata
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_INS     = 3'd1;
  localparam logic [2:0] ST_INS_CMP = 3'd2;
  localparam logic [2:0] ST_REM     = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  logic [2:0]                state;
  logic [PTR_W-1:0]          head;
  logic [CNT_W-1:0]          count;
  logic [PTR_W-1:0]          pos;
  logic [CNT_W-1:0]          steps;
  logic signed [VALUE_W-1:0] val;
  logic signed [VALUE_W-1:0] res_value;
  logic                      res_hit;
  logic                      res_ovf;

  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_hit;
  logic                      out_ovf;
  logic [OCC_W-1:0]          out_occ;

  logic [CNT_W:0]            tail_sum;
  logic [PTR_W-1:0]          tail;
  logic [PTR_W-1:0]          prev_pos;
  logic [PTR_W-1:0]          next_head;
  logic                      moves;
  logic                      load_out;

  always_comb begin
    tail_sum  = (CNT_W+1)'(head) + (CNT_W+1)'(count);
    if (tail_sum >= (CNT_W+1)'(CAPACITY)) begin
      tail = PTR_W'(tail_sum - (CNT_W+1)'(CAPACITY));
    end else begin
      tail = PTR_W'(tail_sum);
    end
    prev_pos  = (pos == '0) ? LAST_PTR : pos - 1'b1;
    next_head = (head == LAST_PTR) ? '0 : head + 1'b1;
    moves     = (val < mem_rdata);
    load_out  = (state == ST_DONE) && (!out_valid || rsp.ready);
  end

  always_comb begin
    mem_we    = ((state == ST_INS) && (steps == '0)) || (state == ST_INS_CMP);
    mem_waddr = pos;
    mem_wdata = ((state == ST_INS_CMP) && moves) ? mem_rdata : val;
    mem_raddr = (state == ST_IDLE) ? head : prev_pos;
  end

  assign req.ready         = (state == ST_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.removed_value = out_value;
  assign rsp.removed_valid = out_hit;
  assign rsp.overflow      = out_ovf;
  assign rsp.occupancy     = out_occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            val       <= req.value;
            res_value <= '0;
            res_hit   <= 1'b0;
            res_ovf   <= 1'b0;
            if (req.req_type == REQ_INSERT) begin
              if (count == FULL_CNT) begin
                res_ovf <= 1'b1;
                state   <= ST_DONE;
              end else begin
                pos   <= tail;
                steps <= count;
                state <= ST_INS;
              end
            end else if (count == '0) begin
              state <= ST_DONE;
            end else begin
              state <= ST_REM;
            end
          end
        end
        ST_INS: begin
          if (steps == '0) begin
            count <= count + 1'b1;
            state <= ST_DONE;
          end else begin
            state <= ST_INS_CMP;
          end
        end
        ST_INS_CMP: begin
          if (moves) begin
            pos   <= prev_pos;
            steps <= steps - 1'b1;
            state <= ST_INS;
          end else begin
            count <= count + 1'b1;
            state <= ST_DONE;
          end
        end
        ST_REM: begin
          res_value <= mem_rdata;
          res_hit   <= 1'b1;
          head      <= next_head;
          count     <= count - 1'b1;
          state     <= ST_DONE;
        end
        ST_DONE: begin
          if (load_out) begin
            out_value <= res_value;
            out_hit   <= res_hit;
            out_ovf   <= res_ovf;
            out_occ   <= OCC_W'(32'(count));
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count above capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_REM || state == ST_DONE) |-> !mem_we)
    else $error("store written outside an insertion step");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REM) |=> (count == $past(count) - 1'b1))
    else $error("remove did not lower the count by one");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_hit && out_ovf))
    else $error("remove hit and overflow reported together");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ovf) |-> (out_occ == OCC_W'(32'(FULL_CNT))))
    else $error("overflow reported below capacity");

endmodule

`default_nettype wire

// ----- src/sorted_insert_pop_min_queue_top.sv -----
// ----------------------------------------------------------------------------
// Sorted insert / pop-min queue
// Bounded ascending queue of signed 32-bit values with one result per request.
// ----------------------------------------------------------------------------
// Requests are taken one at a time and the result is held in an output
// register, so a new request can be taken while an earlier result waits.
// A remove reads the head entry; an insert into a full queue or a remove from
// an empty queue goes straight to its result. An insert walks back from the
// tail over the entries it moves; each insertion step needs one registered
// read of the store before its compare. Equal values keep their arrival order.
// No clearing pass follows reset: entries are only read after being written.
`default_nettype none

module sorted_insert_pop_min_queue_top
  import sipq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  wire logic  clk,
  input  wire logic  rst,
  sipq_req_if.sink   req,
  sipq_rsp_if.source rsp
);

  localparam int PTR_W = $clog2(CAPACITY);

  logic                      mem_we;
  logic [PTR_W-1:0]          mem_waddr;
  logic signed [VALUE_W-1:0] mem_wdata;
  logic [PTR_W-1:0]          mem_raddr;
  logic signed [VALUE_W-1:0] mem_rdata;

  sipq_ram #(
    .CAPACITY (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sipq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

`default_nettype wire
